FILE: rtl/ilha_pkg.sv
// Shared types, constants and tag helpers of the implicit-list heap allocator.
`default_nettype none
package ilha_pkg;

   localparam int ADDR_W = 17;
   localparam int TAG_W  = 15;

   localparam logic [ADDR_W-1:0] FIRST_BP   = 17'd8;
   localparam logic [ADDR_W-1:0] LIVE_START = 17'd16;
   localparam logic [ADDR_W-1:0] MIN_BLOCK  = 17'd16;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_OOM  = 2'd1;
   localparam logic [1:0] STAT_NULL = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic CSR_CHUNK  = 1'b0;
   localparam logic CSR_POLICY = 1'b1;

   localparam logic POLICY_FIRST = 1'b0;
   localparam logic POLICY_NEXT  = 1'b1;

   localparam logic [16:0] CHUNK_RESET  = 17'd4096;
   localparam logic        POLICY_RESET = POLICY_NEXT;

   typedef struct packed {
      logic [16:0] chunk_bytes;
      logic        fit_policy;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  data;
   } tag_req_type;

   function automatic logic [ADDR_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
      return {tag[TAG_W-1:1], 3'b000};
   endfunction

   function automatic logic [TAG_W-1:0] make_tag(input logic [ADDR_W-1:0] size,
                                                 input logic alloc);
      return {size[ADDR_W-1:3], alloc};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/implicit_list_heap_allocator.sv
// Top level: configuration registers, request sequencer and boundary-tag memory.
// Steps: a null free answers straight from idle; other requests walk the heap with one
// tag read and one decode per block visited, plus growth (one check, three tag writes),
// coalescing (two reads, a decode, up to two writes) and a split; the first request adds layout.
// Throughput: one request at a time, set by the single tag memory port; results never stall.
// Reset: synchronous; clears heap layout, heap end and rover; no memory clearing pass.
`default_nettype none
module implicit_list_heap_allocator #(
   parameter int HEAP_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_type,
   input  wire logic [15:0] req_size,
   input  wire logic [15:0] req_block_addr,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_result_addr,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_wdata
);
   import ilha_pkg::*;

   localparam int DEPTH = HEAP_BYTES / 4;
   localparam int IW    = $clog2(DEPTH);

   logic [16:0]  chunk_ff;
   logic         policy_ff;
   cfg_type      cfg;
   tag_req_type  tag_req;
   logic [14:0]  tag_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff  <= CHUNK_RESET;
         policy_ff <= POLICY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK:  chunk_ff  <= csr_wdata;
            CSR_POLICY: policy_ff <= csr_wdata[0];
         endcase
      end
   end

   assign cfg = '{chunk_bytes: chunk_ff, fit_policy: policy_ff};

   ilha_seq #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_type        (req_type),
      .req_size        (req_size),
      .req_block_addr  (req_block_addr),
      .cfg             (cfg),
      .busy            (busy),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_result_addr (rsp_result_addr),
      .tag_req         (tag_req),
      .tag_rdata       (tag_rdata)
   );

   ilha_tag_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (tag_req.we),
      .addr  (tag_req.addr[IW+1:2]),
      .wdata (tag_req.data),
      .rdata (tag_rdata)
   );
endmodule
`default_nettype wire

FILE: rtl/ilha_tag_ram.sv
// Boundary-tag memory: one port, synchronous write, registered read.
`default_nettype none
module ilha_tag_ram #(
   parameter int DEPTH = 16384,
   parameter int IW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [IW-1:0] addr,
   input  wire logic [14:0]   wdata,
   output logic      [14:0]   rdata
);
   logic [14:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/ilha_seq.sv
// Request sequencer: layout, fit search, growth, split, free check and coalescing.
`default_nettype none
module ilha_seq #(
   parameter int HEAP_BYTES = 65536
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_type,
   input  wire logic [15:0]          req_size,
   input  wire logic [15:0]          req_block_addr,
   input  wire ilha_pkg::cfg_type    cfg,
   output logic                      busy,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_result_addr,
   output ilha_pkg::tag_req_type     tag_req,
   input  wire logic [14:0]          tag_rdata
);
   import ilha_pkg::*;

   typedef enum logic [23:0] {
      S_IDLE     = 24'd1 << 0,
      S_LAY0     = 24'd1 << 1,
      S_LAY1     = 24'd1 << 2,
      S_LAY2     = 24'd1 << 3,
      S_LAY3     = 24'd1 << 4,
      S_GROW_CHK = 24'd1 << 5,
      S_GROW_WH  = 24'd1 << 6,
      S_GROW_WF  = 24'd1 << 7,
      S_GROW_WE  = 24'd1 << 8,
      S_MRG_RDP  = 24'd1 << 9,
      S_MRG_RDN  = 24'd1 << 10,
      S_MRG_DEC  = 24'd1 << 11,
      S_MRG_WH   = 24'd1 << 12,
      S_MRG_WF   = 24'd1 << 13,
      S_SRCH_RD  = 24'd1 << 14,
      S_SRCH_CHK = 24'd1 << 15,
      S_LIVE_RD  = 24'd1 << 16,
      S_LIVE_CHK = 24'd1 << 17,
      S_FREE_WH  = 24'd1 << 18,
      S_FREE_WF  = 24'd1 << 19,
      S_PLC_W0   = 24'd1 << 20,
      S_PLC_W1   = 24'd1 << 21,
      S_PLC_W2   = 24'd1 << 22,
      S_PLC_W3   = 24'd1 << 23
   } state_type;

   state_type         state_ff, state_in;
   logic              type_ff, type_in;
   logic              zero_ff, zero_in;
   logic [15:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0] asize_ff, asize_in;
   logic [ADDR_W-1:0] bp_ff, bp_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] old_ff, old_in;
   logic [ADDR_W-1:0] heap_end_ff, heap_end_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic              pass2_ff, pass2_in;
   logic              layout_ff, layout_in;
   logic              ready_ff, ready_in;
   logic [TAG_W-1:0]  prev_ff, prev_in;
   logic              strobe_ff, strobe_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       result_ff, result_in;

   logic              fin, disp, disp_free, disp_zero, mdone, srch_end;
   logic [1:0]        fin_status;
   logic [15:0]       fin_addr;
   logic [16:0]       gbytes;
   logic [15:0]       gwords;
   logic [17:0]       gsize;
   logic [18:0]       gsum;
   logic [ADDR_W-1:0] tsz, psz, rem, pl_sz, mbp, msz;
   logic [17:0]       rov_lim;
   logic              tal, split;

   assign tsz   = tag_size(tag_rdata);
   assign tal   = tag_rdata[0];
   assign psz   = tag_size(prev_ff);
   assign rem   = 17'(size_ff - asize_ff);
   assign split = rem >= MIN_BLOCK;
   assign pl_sz = split ? asize_ff : size_ff;

   assign gbytes  = layout_ff ? cfg.chunk_bytes :
                    ((asize_ff > cfg.chunk_bytes) ? asize_ff : cfg.chunk_bytes);
   assign gwords  = {1'b0, gbytes[16:2]} + {15'b0, gbytes[2]};
   assign gsize   = {gwords, 2'b00};
   assign gsum    = {2'b00, heap_end_ff} + {1'b0, gsize};
   assign rov_lim = {1'b0, bp_ff} + {1'b0, size_ff};

   always_comb begin
      mbp = bp_ff;
      msz = size_ff;
      if (!tal) begin
         msz = 17'(msz + tsz);
      end
      if (!prev_ff[0]) begin
         msz = 17'(msz + psz);
         mbp = 17'(bp_ff - psz);
      end
   end

   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      zero_in     = zero_ff;
      addr_in     = addr_ff;
      asize_in    = asize_ff;
      bp_in       = bp_ff;
      size_in     = size_ff;
      old_in      = old_ff;
      heap_end_in = heap_end_ff;
      rover_in    = rover_ff;
      pass2_in    = pass2_ff;
      layout_in   = layout_ff;
      ready_in    = ready_ff;
      prev_in     = prev_ff;
      status_in   = status_ff;
      result_in   = result_ff;
      strobe_in   = 1'b0;
      fin         = 1'b0;
      fin_status  = STAT_DONE;
      fin_addr    = 16'd0;
      disp        = 1'b0;
      disp_free   = (type_ff == REQ_FREE);
      disp_zero   = zero_ff;
      mdone       = 1'b0;
      srch_end    = 1'b0;
      tag_req     = '{we: 1'b0, addr: 17'(bp_ff - 17'd4), data: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in  = req_type;
               zero_in  = (req_size == 16'd0);
               addr_in  = req_block_addr;
               asize_in = (req_size <= 16'd8) ? MIN_BLOCK :
                          (({1'b0, req_size} + 17'd15) & ~17'd7);
               if (req_type == REQ_FREE && req_block_addr == 16'd0) begin
                  fin        = 1'b1;
                  fin_status = STAT_NULL;
               end else if (!ready_ff) begin
                  layout_in = 1'b1;
                  state_in  = S_LAY0;
               end else begin
                  disp      = 1'b1;
                  disp_free = (req_type == REQ_FREE);
                  disp_zero = (req_size == 16'd0);
               end
            end
         end
         S_LAY0: begin
            tag_req  = '{we: 1'b1, addr: 17'd0, data: make_tag(17'd0, 1'b0)};
            state_in = S_LAY1;
         end
         S_LAY1: begin
            tag_req  = '{we: 1'b1, addr: 17'd4, data: make_tag(17'd8, 1'b1)};
            state_in = S_LAY2;
         end
         S_LAY2: begin
            tag_req  = '{we: 1'b1, addr: 17'd8, data: make_tag(17'd8, 1'b1)};
            state_in = S_LAY3;
         end
         S_LAY3: begin
            tag_req     = '{we: 1'b1, addr: 17'd12, data: make_tag(17'd0, 1'b1)};
            heap_end_in = 17'd16;
            rover_in    = FIRST_BP;
            ready_in    = 1'b1;
            state_in    = S_GROW_CHK;
         end
         S_GROW_CHK: begin
            if (gsize == 18'd0 || gsum > 19'(HEAP_BYTES)) begin
               if (layout_ff) begin
                  layout_in = 1'b0;
                  disp      = 1'b1;
               end else begin
                  fin        = 1'b1;
                  fin_status = STAT_OOM;
               end
            end else begin
               bp_in    = heap_end_ff;
               size_in  = gsize[16:0];
               state_in = S_GROW_WH;
            end
         end
         S_GROW_WH: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff - 17'd4), data: make_tag(size_ff, 1'b0)};
            state_in = S_GROW_WF;
         end
         S_GROW_WF: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff + size_ff - 17'd8),
                         data: make_tag(size_ff, 1'b0)};
            state_in = S_GROW_WE;
         end
         S_GROW_WE: begin
            tag_req     = '{we: 1'b1, addr: 17'(bp_ff + size_ff - 17'd4),
                            data: make_tag(17'd0, 1'b1)};
            heap_end_in = 17'(heap_end_ff + size_ff);
            state_in    = S_MRG_RDP;
         end
         S_MRG_RDP: begin
            tag_req  = '{we: 1'b0, addr: 17'(bp_ff - 17'd8), data: '0};
            state_in = S_MRG_RDN;
         end
         S_MRG_RDN: begin
            tag_req  = '{we: 1'b0, addr: 17'(bp_ff + size_ff - 17'd4), data: '0};
            prev_in  = tag_rdata;
            state_in = S_MRG_DEC;
         end
         S_MRG_DEC: begin
            if (prev_ff[0] && tal) begin
               mdone = 1'b1;
            end else begin
               bp_in    = mbp;
               size_in  = msz;
               state_in = S_MRG_WH;
            end
         end
         S_MRG_WH: begin
            tag_req = '{we: 1'b1, addr: 17'(bp_ff - 17'd4), data: make_tag(size_ff, 1'b0)};
            if (rover_ff > bp_ff && {1'b0, rover_ff} < rov_lim) begin
               rover_in = bp_ff;
            end
            state_in = S_MRG_WF;
         end
         S_MRG_WF: begin
            tag_req = '{we: 1'b1, addr: 17'(bp_ff + size_ff - 17'd8),
                        data: make_tag(size_ff, 1'b0)};
            mdone   = 1'b1;
         end
         S_SRCH_RD: begin
            if (bp_ff < heap_end_ff && (!pass2_ff || bp_ff < old_ff)) begin
               tag_req  = '{we: 1'b0, addr: 17'(bp_ff - 17'd4), data: '0};
               state_in = S_SRCH_CHK;
            end else begin
               srch_end = 1'b1;
            end
         end
         S_SRCH_CHK: begin
            if (tsz == 17'd0) begin
               srch_end = 1'b1;
            end else if (!tal && tsz >= asize_ff) begin
               if (cfg.fit_policy == POLICY_NEXT) begin
                  rover_in = bp_ff;
               end
               size_in  = tsz;
               state_in = S_PLC_W0;
            end else begin
               bp_in    = 17'(bp_ff + tsz);
               state_in = S_SRCH_RD;
            end
         end
         S_LIVE_RD: begin
            if (bp_ff < heap_end_ff) begin
               tag_req  = '{we: 1'b0, addr: 17'(bp_ff - 17'd4), data: '0};
               state_in = S_LIVE_CHK;
            end else begin
               fin        = 1'b1;
               fin_status = STAT_NULL;
            end
         end
         S_LIVE_CHK: begin
            if (tsz == 17'd0 || bp_ff > {1'b0, addr_ff} ||
                (bp_ff == {1'b0, addr_ff} && !tal)) begin
               fin        = 1'b1;
               fin_status = STAT_NULL;
            end else if (bp_ff == {1'b0, addr_ff}) begin
               size_in  = tsz;
               state_in = S_FREE_WH;
            end else begin
               bp_in    = 17'(bp_ff + tsz);
               state_in = S_LIVE_RD;
            end
         end
         S_FREE_WH: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff - 17'd4), data: make_tag(size_ff, 1'b0)};
            state_in = S_FREE_WF;
         end
         S_FREE_WF: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff + size_ff - 17'd8),
                         data: make_tag(size_ff, 1'b0)};
            state_in = S_MRG_RDP;
         end
         S_PLC_W0: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff - 17'd4), data: make_tag(pl_sz, 1'b1)};
            state_in = S_PLC_W1;
         end
         S_PLC_W1: begin
            tag_req = '{we: 1'b1, addr: 17'(bp_ff + pl_sz - 17'd8),
                        data: make_tag(pl_sz, 1'b1)};
            if (split) begin
               state_in = S_PLC_W2;
            end else begin
               fin      = 1'b1;
               fin_addr = bp_ff[15:0];
            end
         end
         S_PLC_W2: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff + asize_ff - 17'd4),
                         data: make_tag(rem, 1'b0)};
            state_in = S_PLC_W3;
         end
         S_PLC_W3: begin
            tag_req  = '{we: 1'b1, addr: 17'(bp_ff + size_ff - 17'd8),
                         data: make_tag(rem, 1'b0)};
            fin      = 1'b1;
            fin_addr = bp_ff[15:0];
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (srch_end) begin
         if (cfg.fit_policy == POLICY_NEXT && !pass2_ff) begin
            pass2_in = 1'b1;
            bp_in    = FIRST_BP;
            state_in = S_SRCH_RD;
         end else begin
            if (cfg.fit_policy == POLICY_NEXT) begin
               rover_in = bp_ff;
            end
            state_in = S_GROW_CHK;
         end
      end

      if (mdone) begin
         if (layout_ff) begin
            layout_in = 1'b0;
            disp      = 1'b1;
         end else if (type_ff == REQ_FREE) begin
            fin = 1'b1;
         end else begin
            state_in = S_PLC_W0;
         end
      end

      if (disp) begin
         if (!disp_free && disp_zero) begin
            fin        = 1'b1;
            fin_status = STAT_NULL;
         end else if (disp_free) begin
            bp_in    = LIVE_START;
            state_in = S_LIVE_RD;
         end else begin
            bp_in    = (cfg.fit_policy == POLICY_NEXT) ? rover_ff : FIRST_BP;
            old_in   = rover_ff;
            pass2_in = 1'b0;
            state_in = S_SRCH_RD;
         end
      end

      if (fin) begin
         strobe_in = 1'b1;
         status_in = fin_status;
         result_in = fin_addr;
         state_in  = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         heap_end_ff <= '0;
         rover_ff    <= '0;
         ready_ff    <= 1'b0;
         layout_ff   <= 1'b0;
         pass2_ff    <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         heap_end_ff <= heap_end_in;
         rover_ff    <= rover_in;
         ready_ff    <= ready_in;
         layout_ff   <= layout_in;
         pass2_ff    <= pass2_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      zero_ff   <= zero_in;
      addr_ff   <= addr_in;
      asize_ff  <= asize_in;
      bp_ff     <= bp_in;
      size_ff   <= size_in;
      old_ff    <= old_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_addr = result_ff;
endmodule
`default_nettype wire

FILE: rtl/ilha_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module ilha_assertions (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_result_addr
);
   import ilha_pkg::*;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result transfer while busy");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("request finished without a result");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither busy nor answered");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_DONE) |-> (rsp_result_addr == 16'd0))
      else $error("address on a failed request");

   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status <= STAT_NULL && rsp_result_addr[2:0] == 3'd0))
      else $error("bad status or misaligned block");
endmodule

bind implicit_list_heap_allocator ilha_assertions u_chk (.*);
`default_nettype wire

FILE: tb/ilha_checker.sv
// Checker for the implicit-list heap allocator: predicts each response and compares.
`timescale 1ns / 1ps
module ilha_checker
   import ilha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_type,
   input  wire logic [15:0] req_size,
   input  wire logic [15:0] req_block_addr,
   input  wire logic        rsp_strobe,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [15:0] rsp_result_addr,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_wdata,
   output int               errors,
   output int               outstanding
);

   localparam int unsigned HEAP_LIMIT = 65536;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] addr;
   } answer_t;

   answer_t     answers[$];
   bit [14:0]   tags[16384];
   int unsigned heap_top;
   int unsigned rover;
   bit          laid_out;
   int unsigned chunk;
   bit          policy;

   function automatic int unsigned tag_at(int unsigned a);
      return tags[(a >> 2) & 16383];
   endfunction

   function automatic void put_tag(int unsigned a, int unsigned size, int unsigned al);
      tags[(a >> 2) & 16383] = 15'(((size >> 3) << 1) | (al & 1));
   endfunction

   function automatic int unsigned size_at(int unsigned a);
      return (tag_at(a) >> 1) << 3;
   endfunction

   function automatic int unsigned used_at(int unsigned a);
      return tag_at(a) & 1;
   endfunction

   function automatic int unsigned blk_size(int unsigned bp);
      return size_at(bp - 4);
   endfunction

   function automatic void mark_block(int unsigned bp, int unsigned size, int unsigned al);
      put_tag(bp - 4, size, al);
      put_tag(bp + size - 8, size, al);
   endfunction

   function automatic int unsigned coalesce(int unsigned bp_in);
      int unsigned bp, size, p_al, p_sz, n_al;
      bp   = bp_in;
      size = blk_size(bp);
      p_al = used_at(bp - 8);
      p_sz = size_at(bp - 8);
      n_al = used_at(bp + size - 4);
      if (p_al && n_al) return bp;
      if (!n_al) size += blk_size(bp + size);
      if (!p_al) begin
         size += p_sz;
         bp   -= p_sz;
      end
      mark_block(bp, size, 0);
      if (rover > bp && rover < bp + size) rover = bp;
      return bp;
   endfunction

   function automatic int unsigned extend(int unsigned bytes);
      int unsigned w, size, bp;
      w = bytes >> 2;
      if (w & 1) w++;
      size = w << 2;
      if (size == 0 || heap_top + size > HEAP_LIMIT) return 0;
      bp = heap_top;
      mark_block(bp, size, 0);
      put_tag(bp + size - 4, 0, 1);
      heap_top += size;
      return coalesce(bp);
   endfunction

   function automatic void init_heap();
      int unsigned dummy;
      put_tag(0, 0, 0);
      put_tag(4, 8, 1);
      put_tag(8, 8, 1);
      put_tag(12, 0, 1);
      heap_top = 16;
      rover    = 8;
      laid_out = 1;
      dummy    = extend(chunk);
   endfunction

   function automatic bit fits(int unsigned bp, int unsigned asize);
      return !used_at(bp - 4) && blk_size(bp) >= asize;
   endfunction

   function automatic int unsigned locate_fit(int unsigned asize);
      int unsigned bp, old;
      if (policy == POLICY_FIRST) begin
         for (bp = 8; bp < heap_top && blk_size(bp) > 0; bp += blk_size(bp))
            if (fits(bp, asize)) return bp;
         return 0;
      end
      old = rover;
      for (bp = old; bp < heap_top && blk_size(bp) > 0; bp += blk_size(bp))
         if (fits(bp, asize)) begin
            rover = bp;
            return bp;
         end
      for (bp = 8; bp < old && bp < heap_top && blk_size(bp) > 0; bp += blk_size(bp))
         if (fits(bp, asize)) begin
            rover = bp;
            return bp;
         end
      rover = bp;
      return 0;
   endfunction

   function automatic void carve(int unsigned bp, int unsigned asize);
      int unsigned csize;
      csize = blk_size(bp);
      if (csize - asize >= 16) begin
         mark_block(bp, asize, 1);
         mark_block(bp + asize, csize - asize, 0);
      end else begin
         mark_block(bp, csize, 1);
      end
   endfunction

   function automatic bit is_allocated(int unsigned addr);
      int unsigned bp;
      for (bp = 16; bp < heap_top && blk_size(bp) > 0; bp += blk_size(bp)) begin
         if (bp == addr) return used_at(bp - 4) != 0;
         if (bp > addr) return 0;
      end
      return 0;
   endfunction

   function automatic answer_t serve(logic kind, int unsigned size, int unsigned addr);
      answer_t     ans;
      int unsigned asize, bp, ext, dummy;
      ans.status = STAT_DONE;
      ans.addr   = '0;
      if (kind == REQ_ALLOC) begin
         if (!laid_out) init_heap();
         if (size == 0) begin
            ans.status = STAT_NULL;
         end else begin
            asize = (size <= 8) ? 16 : 8 * ((size + 15) / 8);
            bp = locate_fit(asize);
            if (bp == 0) begin
               ext = (asize > chunk) ? asize : chunk;
               bp  = extend(ext);
            end
            if (bp == 0) begin
               ans.status = STAT_OOM;
            end else begin
               carve(bp, asize);
               ans.addr = 16'(bp);
            end
         end
      end else if (addr == 0) begin
         ans.status = STAT_NULL;
      end else begin
         if (!laid_out) init_heap();
         if (is_allocated(addr)) begin
            mark_block(addr, blk_size(addr), 0);
            dummy = coalesce(addr);
         end else begin
            ans.status = STAT_NULL;
         end
      end
      return ans;
   endfunction

   assign outstanding = answers.size();

   always @(posedge clock) begin
      answer_t want;
      if (reset) begin
         answers.delete();
         foreach (tags[i]) tags[i] = '0;
         heap_top = 0;
         rover    = 0;
         laid_out = 0;
         chunk    = CHUNK_RESET;
         policy   = POLICY_RESET;
         errors   = 0;
      end else begin
         if (rsp_strobe) begin
            if (answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected response status %0d addr %0d", $time,
                        rsp_status, rsp_result_addr);
            end else begin
               want = answers.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
               end
               if (rsp_result_addr !== want.addr) begin
                  errors++;
                  $display("%0t: result_addr expected %0d actual %0d", $time, want.addr,
                           rsp_result_addr);
               end
            end
         end
         if (start && !busy)
            answers.push_back(serve(req_type, req_size, req_block_addr));
         if (csr_we) begin
            if (csr_index == CSR_CHUNK) chunk = csr_wdata;
            else policy = csr_wdata[0];
         end
      end
   end

endmodule

FILE: tb/implicit_list_heap_allocator_tb.sv
// Testbench top for the implicit-list heap allocator: stimulus, phases and verdict.
`timescale 1ns / 1ps
module implicit_list_heap_allocator_tb;
   import ilha_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_type = REQ_ALLOC;
   logic [15:0] req_size = '0;
   logic [15:0] req_block_addr = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_result_addr;
   logic        csr_we = 0;
   logic        csr_index = CSR_CHUNK;
   logic [16:0] csr_wdata = '0;
   int          errors;
   int          outstanding;

   int          live[$];
   int          freed[$];
   int          n_alloc, n_free, n_granted;

   implicit_list_heap_allocator u_top (.*);

   ilha_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_strobe && rsp_status == STAT_DONE && rsp_result_addr != 16'd0) begin
         live.push_back(rsp_result_addr);
         n_granted++;
      end
   end

   task automatic transfer(logic kind, int size, int addr);
      req_type       <= kind;
      req_size       <= 16'(size);
      req_block_addr <= 16'(addr);
      start          <= 1;
      do @(posedge clock); while (busy);
      if (kind == REQ_ALLOC) n_alloc++;
      else n_free++;
   endtask

   task automatic hold(int n);
      start <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= 17'(value);
      @(posedge clock);
      csr_we    <= 0;
   endtask

   task automatic release_live(int idx);
      int a;
      a = live[idx];
      live.delete(idx);
      freed.push_back(a);
      if (freed.size() > 64) void'(freed.pop_front());
      transfer(REQ_FREE, $urandom, a);
   endtask

   task automatic random_item();
      int r, s;
      r = $urandom_range(0, 99);
      if (live.size() > 200) r = r + 40;
      if (r < 50) begin
         s = $urandom_range(0, 99);
         if (s < 85) transfer(REQ_ALLOC, $urandom_range(1, 256), $urandom);
         else if (s < 95) transfer(REQ_ALLOC, $urandom_range(257, 4096), $urandom);
         else if (s < 97) transfer(REQ_ALLOC, 0, $urandom);
         else transfer(REQ_ALLOC, $urandom_range(0, 65535), $urandom);
      end else if (r < 130 && live.size() > 0) begin
         release_live($urandom_range(0, live.size() - 1));
      end else begin
         s = $urandom_range(0, 3);
         if (s == 0) transfer(REQ_FREE, $urandom, 0);
         else if (s == 1 || freed.size() == 0)
            transfer(REQ_FREE, $urandom, $urandom_range(1, 65535));
         else if (s == 2) transfer(REQ_FREE, $urandom, freed[$urandom_range(0, freed.size() - 1)]);
         else transfer(REQ_FREE, $urandom, freed[$urandom_range(0, freed.size() - 1)] + 4);
      end
   endtask

   initial begin
      int idle_pct[4] = '{0, 45, 0, 17};
      int chunks[4]   = '{16, 4096, 65536, 1000};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // first chunk too large for the heap: layout holds prologue and epilogue only
      write_reg(CSR_CHUNK, 65536);
      write_reg(CSR_POLICY, POLICY_FIRST);
      transfer(REQ_FREE, 0, 0);
      transfer(REQ_ALLOC, 0, 0);
      transfer(REQ_ALLOC, 8, 0);
      drain();
      write_reg(CSR_CHUNK, 16);
      transfer(REQ_ALLOC, 1, 0);
      transfer(REQ_ALLOC, 8, 0);
      transfer(REQ_ALLOC, 9, 0);
      transfer(REQ_ALLOC, 24, 0);
      transfer(REQ_ALLOC, 65535, 0);
      transfer(REQ_ALLOC, 40000, 0);
      transfer(REQ_FREE, 0, 3);
      transfer(REQ_FREE, 0, 65535);
      transfer(REQ_FREE, 0, 8);
      drain();
      write_reg(CSR_POLICY, POLICY_NEXT);
      release_live(1);
      transfer(REQ_FREE, 0, freed[$]);
      release_live(0);
      release_live(live.size() - 1);
      transfer(REQ_ALLOC, 16, 0);
      transfer(REQ_ALLOC, 30000, 0);
      transfer(REQ_ALLOC, 12, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_CHUNK, chunks[ph]);
         write_reg(CSR_POLICY, ph[0]);
         for (int i = 0; i < 270; i++) begin
            random_item();
            if ($urandom_range(0, 99) < idle_pct[ph]) hold($urandom_range(1, 5));
         end
         drain();
         while (live.size() > 40) release_live($urandom_range(0, live.size() - 1));
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d allocate and %0d free requests over four phases; %0d granted.",
               n_alloc, n_free, n_granted);
      if (errors == 0 && outstanding == 0)
         $display("** implicit_list_heap_allocator: PASSED **");
      else
         $display("** implicit_list_heap_allocator: FAILED **");
      $finish;
   end

   initial begin
      #1s;
      $display("Timed out.");
      $display("** implicit_list_heap_allocator: FAILED **");
      $finish;
   end

endmodule
